@@ design/ndft_pkg.sv @@
// Shared types, constants and twiddle table generation for the direct DFT engine.
package ndft_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int IN_DATA_W  = 32;
    localparam int BIN_W      = 23;
    localparam int IDX_OUT_W  = 6;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * BIN_W - IDX_OUT_W;

    // Bin scaling: Q2.30 sums back to Q1.15, round half up, saturate
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_HALF = 16384;
    localparam int BIN_MAX    = 4194303;
    localparam int BIN_MIN    = -4194304;

    // pi/2 and 1.0 in Q61 for the twiddle series
    localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
    localparam logic [63:0] Q61_ONE     = 64'h2000000000000000;
    localparam logic signed [17:0] TW_MAX = 18'sd32767;

    // Sequencer states
    typedef enum logic {
        S_LOAD,
        S_RUN
    } state_t;

    // Per-term tag that travels down the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

    // Restoring divide, elaboration only
    function automatic logic [63:0] tw_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // (a*b) >> 61 in Q61
    function automatic logic [63:0] tw_qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // Taylor series of cos (odd=0) or sin (odd=1) over the first quadrant
    function automatic logic [63:0] tw_series(input logic [63:0] x, input logic odd);
        logic [63:0]        term;
        logic [63:0]        x2;
        logic [63:0]        j;
        logic signed [63:0] sum;
        logic               neg;
        term = odd ? x : Q61_ONE;
        x2   = tw_qmul(x, x);
        sum  = $signed(term);
        j    = odd ? 64'd2 : 64'd1;
        neg  = 1'b1;
        // a zero term stays zero, so running every step is harmless
        for (int i = 0; i < 30; i++)
        begin
            if (j < 64'd60)
            begin
                term = tw_udiv(tw_qmul(term, x2), j * (j + 64'd1));
                if (neg)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
                neg = !neg;
                j   = j + 64'd2;
            end
        end
        if (sum < 0)
            return 64'd0;
        return sum;
    endfunction

    // Q61 to Q1.15, round half up
    function automatic logic signed [17:0] tw_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'h0000200000000000) >> 46;
        return $signed(r[17:0]);
    endfunction

    // Twiddle entry m of an n-point table: {sin, cos}, each Q1.15
    function automatic logic [31:0] tw_entry(input int m, input int points);
        logic [63:0]        pts;
        logic [63:0]        qd;
        logic [63:0]        rd;
        logic [63:0]        t;
        logic [63:0]        quad;
        logic [63:0]        rem;
        logic [63:0]        phi;
        logic signed [17:0] c;
        logic signed [17:0] s;
        logic signed [17:0] cv;
        logic signed [17:0] sv;
        pts  = 64'(points);
        qd   = tw_udiv(HALF_PI_Q61, pts);
        rd   = HALF_PI_Q61 - qd * pts;
        t    = 64'(4 * m);
        quad = tw_udiv(t, pts);
        rem  = t - quad * pts;
        phi  = qd * rem + tw_udiv(rd * rem, pts);
        c    = tw_q15(tw_series(phi, 1'b0));
        s    = tw_q15(tw_series(phi, 1'b1));
        // fold the quadrant back in
        case (quad)
            64'd0:
            begin
                cv = c;
                sv = s;
            end
            64'd1:
            begin
                cv = -s;
                sv = c;
            end
            64'd2:
            begin
                cv = -c;
                sv = -s;
            end
            default:
            begin
                cv = s;
                sv = -c;
            end
        endcase
        if (cv > TW_MAX)
            cv = TW_MAX;
        if (sv > TW_MAX)
            sv = TW_MAX;
        return {sv[15:0], cv[15:0]};
    endfunction

endpackage

@@ design/ndft_sample_store.sv @@
// Sample memory: one write port for loading, one registered read port for the MAC.
module ndft_sample_store
    import ndft_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [IN_DATA_W-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [IN_DATA_W-1:0] rd_data
);

    logic [IN_DATA_W-1:0] mem [DEPTH];
    logic [IN_DATA_W-1:0] rd_data_reg;

    // write on load, read on issue; read data holds while stalled
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/ndft_twiddle_rom.sv @@
// Twiddle ROM: Q1.15 cos/sin of 2*pi*m/POINTS, built at elaboration, registered read.
module ndft_twiddle_rom
    import ndft_pkg::*;
#(
    parameter int POINTS = 64,
    parameter int AW     = 6
)
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic signed [SAMPLE_W-1:0] tw_cos,
    output logic signed [SAMPLE_W-1:0] tw_sin
);

    logic [2*SAMPLE_W-1:0] rom [POINTS];
    logic [2*SAMPLE_W-1:0] entry_reg;

    // constant table
    for (genvar g = 0; g < POINTS; g++)
    begin : g_rom
        localparam logic [2*SAMPLE_W-1:0] ENTRY = tw_entry(g, POINTS);
        assign rom[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            entry_reg <= rom[rd_addr];
    end

    assign tw_cos = $signed(entry_reg[SAMPLE_W-1:0]);
    assign tw_sin = $signed(entry_reg[2*SAMPLE_W-1:SAMPLE_W]);

endmodule

@@ design/ndft_cmac.sv @@
// Shared complex multiply-accumulate with bin rounding and saturation.
module ndft_cmac
    import ndft_pkg::*;
#(
    parameter int ACC_W = 39
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  mac_ctrl_t                  issue,
    input  logic signed [SAMPLE_W-1:0] sample_real,
    input  logic signed [SAMPLE_W-1:0] sample_imag,
    input  logic signed [SAMPLE_W-1:0] tw_cos,
    input  logic signed [SAMPLE_W-1:0] tw_sin,
    output logic                       fin_valid,
    output logic signed [BIN_W-1:0]    fin_real,
    output logic signed [BIN_W-1:0]    fin_imag
);

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'(BIN_MAX);
    localparam logic signed [ACC_W:0] SAT_LO = (ACC_W + 1)'(BIN_MIN);
    localparam logic signed [ACC_W:0] HALF   = (ACC_W + 1)'(ROUND_HALF);

    mac_ctrl_t                 s1_reg;
    mac_ctrl_t                 s2_reg;
    logic                      done_reg;
    logic signed [PROD_W-1:0]  p_rr_reg;
    logic signed [PROD_W-1:0]  p_ii_reg;
    logic signed [PROD_W-1:0]  p_ir_reg;
    logic signed [PROD_W-1:0]  p_ri_reg;
    logic signed [ACC_W-1:0]   acc_real_reg;
    logic signed [ACC_W-1:0]   acc_imag_reg;
    logic signed [ACC_W-1:0]   acc_real_next;
    logic signed [ACC_W-1:0]   acc_imag_next;
    logic signed [PROD_W:0]    term_real;
    logic signed [PROD_W:0]    term_imag;

    // Q2.30 sum back to Q1.15, ties toward +inf, clamped to the bin range
    function automatic logic signed [BIN_W-1:0] round_bin(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        logic signed [ACC_W:0] r;
        t = $signed({a[ACC_W-1], a}) + HALF;
        r = t >>> FRAC_BITS;
        if (r > SAT_HI)
            return BIN_W'(BIN_MAX);
        if (r < SAT_LO)
            return BIN_W'(BIN_MIN);
        return $signed(r[BIN_W-1:0]);
    endfunction

    // pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg   <= issue;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    // real: xr*c + xi*s, imag: xi*c - xr*s
    assign term_real = (PROD_W + 1)'(p_rr_reg) + (PROD_W + 1)'(p_ii_reg);
    assign term_imag = (PROD_W + 1)'(p_ir_reg) - (PROD_W + 1)'(p_ri_reg);

    always_comb
    begin
        acc_real_next = acc_real_reg;
        acc_imag_next = acc_imag_reg;
        if (s2_reg.valid)
        begin
            if (s2_reg.first)
            begin
                acc_real_next = ACC_W'(term_real);
                acc_imag_next = ACC_W'(term_imag);
            end
            else
            begin
                acc_real_next = acc_real_reg + ACC_W'(term_real);
                acc_imag_next = acc_imag_reg + ACC_W'(term_imag);
            end
        end
    end

    // products and accumulators
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_rr_reg     <= sample_real * tw_cos;
            p_ii_reg     <= sample_imag * tw_sin;
            p_ir_reg     <= sample_imag * tw_cos;
            p_ri_reg     <= sample_real * tw_sin;
            acc_real_reg <= acc_real_next;
            acc_imag_reg <= acc_imag_next;
        end
    end

    assign fin_valid = done_reg;
    assign fin_real  = round_bin(acc_real_reg);
    assign fin_imag  = round_bin(acc_imag_reg);

    // a finished bin waiting on the output keeps its value
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && !adv |=> fin_valid && $stable(fin_real) && $stable(fin_imag))
        else $error("finished bin changed while stalled");

    // a bin completes only after its last term has passed s2_reg
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !(s2_reg.valid && s2_reg.last) |=> !done_reg)
        else $error("bin done without a last term");

endmodule

@@ design/naive_dft_engine.sv @@
// Top level of the direct DFT engine: sequencer, output register and datapath hookup.
//
// Usage:
//   Samples enter on the s_axis channel, one complex Q1.15 sample per request,
//   one per cycle while loading. After POINTS samples the block computes all
//   POINTS bins by the direct O(N^2) sum and sends them on m_axis in index
//   order, tlast marking bin POINTS-1.
//   Each bin is accumulated term by term in the single shared complex MAC.
//   s_axis_tready is low while the MAC sequence is issued and rises again
//   as soon as the last term has been issued, so the next frame loads while
//   the last bins drain.
//   If m_axis_tready stays low, the finished bin waits in the output register,
//   the next one waits in the accumulator and the whole MAC pipeline holds;
//   nothing is dropped.
//   Reset (rst_n low, asynchronous) empties the pipeline, clears the load
//   count and the output valid; the sample memory is not cleared and needs
//   no sweep, since a transform reads only freshly loaded samples.
module naive_dft_engine
    import ndft_pkg::*;
#(
    parameter int POINTS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample_real, sample_imag
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // bin_real, bin_imag, bin_index, pad
    output logic                  m_axis_tlast    // bin_last
);

    localparam int IDX_W = $clog2(POINTS);
    localparam int ACC_W = 2 * SAMPLE_W + 1 + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
    localparam logic [IDX_W:0]   PTS_W    = (IDX_W + 1)'(POINTS);

    state_t                     state_reg;
    state_t                     state_next;
    logic [IDX_W-1:0]           load_cnt_reg;
    logic [IDX_W-1:0]           load_cnt_next;
    logic [IDX_W-1:0]           k_reg;
    logic [IDX_W-1:0]           k_next;
    logic [IDX_W-1:0]           n_reg;
    logic [IDX_W-1:0]           n_next;
    logic [IDX_W-1:0]           m_reg;
    logic [IDX_W-1:0]           m_next;
    logic [IDX_W:0]             m_sum;
    logic [IDX_W-1:0]           m_step;
    logic                       load_fire;
    logic                       adv;
    mac_ctrl_t                  issue;

    logic [IN_DATA_W-1:0]       sample_word;
    logic signed [SAMPLE_W-1:0] tw_cos;
    logic signed [SAMPLE_W-1:0] tw_sin;
    logic                       fin_valid;
    logic signed [BIN_W-1:0]    fin_real;
    logic signed [BIN_W-1:0]    fin_imag;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [IDX_W-1:0]           out_k_reg;
    logic [IDX_W-1:0]           out_k_next;
    logic [OUT_DATA_W-1:0]      out_data_reg;
    logic                       out_last_reg;
    logic                       out_load;
    logic [IDX_W+IDX_OUT_W-1:0] out_k_wide;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign load_fire     = s_axis_tvalid && s_axis_tready;

    // twiddle index steps by k, modulo POINTS
    assign m_sum  = {1'b0, m_reg} + {1'b0, k_reg};
    assign m_step = (m_sum >= PTS_W) ? IDX_W'(m_sum - PTS_W) : m_sum[IDX_W-1:0];

    // output handoff and pipeline stall
    assign out_load = fin_valid && (!out_valid_reg || m_axis_tready);
    assign adv      = !fin_valid || out_load;

    // sequencer: load samples, then issue k/n terms
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        m_next        = m_reg;
        issue         = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (load_fire)
                begin
                    if (load_cnt_reg == LAST_IDX)
                    begin
                        load_cnt_next = '0;
                        k_next        = '0;
                        n_next        = '0;
                        m_next        = '0;
                        state_next    = S_RUN;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                issue.valid = adv;
                issue.first = (n_reg == '0);
                issue.last  = (n_reg == LAST_IDX);
                if (adv)
                begin
                    if (n_reg == LAST_IDX)
                    begin
                        n_next = '0;
                        m_next = '0;
                        if (k_reg == LAST_IDX)
                        begin
                            k_next     = '0;
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                        m_next = m_step;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            m_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            k_reg        <= k_next;
            n_reg        <= n_next;
            m_reg        <= m_next;
        end
    end

    // datapath
    ndft_sample_store #(
        .DEPTH (POINTS),
        .AW    (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_fire),
        .wr_addr (load_cnt_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (issue.valid),
        .rd_addr (n_reg),
        .rd_data (sample_word)
    );

    ndft_twiddle_rom #(
        .POINTS (POINTS),
        .AW     (IDX_W)
    ) u_rom (
        .clk     (clk),
        .rd_en   (issue.valid),
        .rd_addr (m_reg),
        .tw_cos  (tw_cos),
        .tw_sin  (tw_sin)
    );

    ndft_cmac #(
        .ACC_W (ACC_W)
    ) u_cmac (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .issue       (issue),
        .sample_real ($signed(sample_word[SAMPLE_W-1:0])),
        .sample_imag ($signed(sample_word[IN_DATA_W-1:SAMPLE_W])),
        .tw_cos      (tw_cos),
        .tw_sin      (tw_sin),
        .fin_valid   (fin_valid),
        .fin_real    (fin_real),
        .fin_imag    (fin_imag)
    );

    // output register
    assign out_k_wide = {{IDX_OUT_W{1'b0}}, out_k_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_k_next     = out_k_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_k_next     = (out_k_reg == LAST_IDX) ? '0 : out_k_reg + 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_k_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_k_reg     <= out_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, out_k_wide[IDX_OUT_W-1:0], fin_imag, fin_real};
            out_last_reg <= (out_k_reg == LAST_IDX);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // no sample loading is half done while terms are issued
    a_run_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> load_cnt_reg == '0)
        else $error("load count not cleared during compute");

    // every bin starts its twiddle walk at index zero
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN && n_reg == '0 |-> m_reg == '0)
        else $error("twiddle index not reset at bin start");

    // the final term of the final bin hands back to loading
    a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid && issue.last && k_reg == LAST_IDX |=> state_reg == S_LOAD)
        else $error("sequencer did not return to load");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the direct DFT engine: frames of samples in, bins checked out.
`timescale 1ns / 1ps

module tb_top;
    import ndft_pkg::*;

    localparam int POINTS = 64;
    localparam logic [63:0] QUARTER_TURN = 64'h3243F6A8885A308D;   // pi/2 in Q61
    localparam logic [63:0] UNITY_Q61    = 64'h2000000000000000;
    localparam longint BIN_TOP    = 4194303;
    localparam longint BIN_BOTTOM = -4194304;

    // Kinds of sample frame sent by send_frame
    typedef enum int {
        FRAME_RANDOM,
        FRAME_SMALL,
        FRAME_EXTREME,
        FRAME_CONST
    } frame_kind_t;

    // One expected bin
    typedef struct packed {
        logic signed [22:0] re;
        logic signed [22:0] im;
        logic [5:0]         idx;
        logic               last;
    } bin_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // sample_real, sample_imag
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // bin_real, bin_imag, bin_index, pad
    logic                  m_axis_tlast;        // bin_last

    // Predictor state
    longint              cos_q15 [POINTS];
    longint              sin_q15 [POINTS];
    logic signed [15:0]  frame_re [POINTS];
    logic signed [15:0]  frame_im [POINTS];
    int                  frame_fill = 0;
    bin_t                expected_bins [$];

    int unsigned errors = 0;
    bit          throttle_on = 1'b1;
    int          ready_hold = 0;

    naive_dft_engine #(.POINTS(POINTS)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Twiddle table: exact integer Taylor series, Q61 down to Q1.15
    // ---------------------------------------------------------------
    function automatic logic [63:0] q61_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[124:61];
    endfunction

    function automatic longint taylor_q61(input logic [63:0] x, input bit odd);
        logic [63:0] term;
        logic [63:0] x2;
        logic [63:0] j;
        longint      acc;
        bit          neg;
        term = odd ? x : UNITY_Q61;
        x2   = q61_mul(x, x);
        acc  = longint'(term);
        j    = odd ? 64'd2 : 64'd1;
        neg  = 1'b1;
        while (j < 64'd60 && term != 64'd0)
        begin
            term = q61_mul(term, x2) / (j * (j + 64'd1));
            acc  = neg ? acc - longint'(term) : acc + longint'(term);
            neg  = !neg;
            j    = j + 64'd2;
        end
        return (acc < 0) ? 0 : acc;
    endfunction

    function automatic longint q61_to_q15(input longint v);
        logic [63:0] r;
        r = (64'(v) + (64'd1 << 45)) >> 46;
        return longint'(r);
    endfunction

    task automatic build_twiddles();
        logic [63:0] step_q;
        logic [63:0] step_r;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] phi;
        longint      c;
        longint      s;
        longint      cv;
        longint      sv;
        step_q = QUARTER_TURN / 64'(POINTS);
        step_r = QUARTER_TURN % 64'(POINTS);
        for (int m = 0; m < POINTS; m++)
        begin
            quad = 64'(4 * m) / 64'(POINTS);
            rem  = 64'(4 * m) % 64'(POINTS);
            phi  = step_q * rem + (step_r * rem) / 64'(POINTS);
            c    = q61_to_q15(taylor_q61(phi, 1'b0));
            s    = q61_to_q15(taylor_q61(phi, 1'b1));
            case (quad)
                64'd0:
                begin
                    cv = c;
                    sv = s;
                end
                64'd1:
                begin
                    cv = -s;
                    sv = c;
                end
                64'd2:
                begin
                    cv = -c;
                    sv = -s;
                end
                default:
                begin
                    cv = s;
                    sv = -c;
                end
            endcase
            // +1.0 does not fit Q1.15
            cos_q15[m] = (cv > 32767) ? 32767 : cv;
            sin_q15[m] = (sv > 32767) ? 32767 : sv;
        end
    endtask

    // Q2.30 sum back to Q1.15, ties up, saturate to 23 bits
    function automatic logic signed [22:0] scale_bin(input longint acc);
        longint r;
        r = (acc + 16384) >>> 15;
        if (r > BIN_TOP)
            r = BIN_TOP;
        if (r < BIN_BOTTOM)
            r = BIN_BOTTOM;
        return r[22:0];
    endfunction

    // Full direct transform of the loaded frame, bins queued in index order
    task automatic queue_transform();
        longint ar;
        longint ai;
        longint xr;
        longint xi;
        int     m;
        bin_t   b;
        for (int k = 0; k < POINTS; k++)
        begin
            ar = 0;
            ai = 0;
            for (int n = 0; n < POINTS; n++)
            begin
                m  = (k * n) % POINTS;
                xr = frame_re[n];
                xi = frame_im[n];
                ar += xr * cos_q15[m] + xi * sin_q15[m];
                ai += xi * cos_q15[m] - xr * sin_q15[m];
            end
            b.re   = scale_bin(ar);
            b.im   = scale_bin(ai);
            b.idx  = 6'(k);
            b.last = (k == POINTS - 1);
            expected_bins.push_back(b);
        end
    endtask

    // ---------------------------------------------------------------
    // Sample request driver: optional gap, then hold until accepted
    // ---------------------------------------------------------------
    task automatic push_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        int gap;
        if (throttle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        do
            @(posedge clk);
        while (!s_axis_tready);
        frame_re[frame_fill] = re;
        frame_im[frame_fill] = im;
        frame_fill++;
        if (frame_fill == POINTS)
        begin
            queue_transform();
            frame_fill = 0;
        end
    endtask

    task automatic wait_drained();
        while (expected_bins.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic send_frame(input frame_kind_t kind);
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic signed [15:0] dc_re;
        logic signed [15:0] dc_im;
        dc_re = pick_extreme();
        dc_im = 16'($urandom);
        for (int n = 0; n < POINTS; n++)
        begin
            case (kind)
                FRAME_SMALL:
                begin
                    re = 16'($urandom_range(0, 64)) - 16'sd32;
                    im = 16'($urandom_range(0, 64)) - 16'sd32;
                end
                FRAME_EXTREME:
                begin
                    re = pick_extreme();
                    im = pick_extreme();
                end
                FRAME_CONST:
                begin
                    re = dc_re;
                    im = dc_im;
                end
                default:
                begin
                    re = 16'($urandom);
                    im = 16'($urandom);
                end
            endcase
            push_sample(re, im);
        end
    endtask

    // ---------------------------------------------------------------
    // Bin checker and output backpressure
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        bin_t want;
        bin_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.re   = m_axis_tdata[22:0];
                got.im   = m_axis_tdata[45:23];
                got.idx  = m_axis_tdata[51:46];
                got.last = m_axis_tlast;
                if (expected_bins.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected bin re=%0d im=%0d idx=%0d last=%0b",
                             $time, got.re, got.im, got.idx, got.last);
                end
                else
                begin
                    want = expected_bins.pop_front();
                    if (got.re !== want.re)
                    begin
                        errors++;
                        $display("%0t: bin %0d real: expected %0d, actual %0d",
                                 $time, want.idx, want.re, got.re);
                    end
                    if (got.im !== want.im)
                    begin
                        errors++;
                        $display("%0t: bin %0d imag: expected %0d, actual %0d",
                                 $time, want.idx, want.im, got.im);
                    end
                    if (got.idx !== want.idx)
                    begin
                        errors++;
                        $display("%0t: bin index: expected %0d, actual %0d",
                                 $time, want.idx, got.idx);
                    end
                    if (got.last !== want.last)
                    begin
                        errors++;
                        $display("%0t: bin %0d last: expected %0b, actual %0b",
                                 $time, want.idx, want.last, got.last);
                    end
                end
            end
            // random stall bursts while throttling
            if (ready_hold > 0)
            begin
                ready_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (throttle_on && $urandom_range(0, 7) == 0)
            begin
                ready_hold = $urandom_range(1, 17) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Hand-picked corner samples (full scale, zero, mixed signs), then zeros
    task automatic test_corner_frame();
        logic signed [15:0] re_list [12] = '{16'sd32767, -16'sd32768, 16'sd32767,
                                             -16'sd32768, 16'sd0, 16'sd32767, 16'sd0,
                                             -16'sd32768, 16'sd0, 16'sd1, -16'sd1,
                                             16'sd16384};
        logic signed [15:0] im_list [12] = '{16'sd32767, -16'sd32768, -16'sd32768,
                                             16'sd32767, 16'sd0, 16'sd0, 16'sd32767,
                                             16'sd0, -16'sd32768, -16'sd1, 16'sd1,
                                             -16'sd16384};
        for (int n = 0; n < POINTS; n++)
        begin
            if (n < 12)
                push_sample(re_list[n], im_list[n]);
            else
                push_sample(16'sd0, 16'sd0);
        end
    endtask

    task automatic test_random_frames();
        send_frame(FRAME_EXTREME);
        send_frame(FRAME_SMALL);
    endtask

    // Sender holds off until every bin of the previous frame is out
    task automatic test_pause_between_frames();
        send_frame(FRAME_CONST);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        @(posedge clk);
        send_frame(FRAME_RANDOM);
    endtask

    // No idling on either side: next frame loads while bins drain
    task automatic test_streaming();
        throttle_on = 1'b0;
        send_frame(FRAME_RANDOM);
        send_frame(FRAME_EXTREME);
    endtask

    initial
    begin
        build_twiddles();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_frame();
        test_random_frames();
        test_pause_between_frames();
        test_streaming();
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (POINTS + 10) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
design/ndft_pkg.sv
design/ndft_sample_store.sv
design/ndft_twiddle_rom.sv
design/ndft_cmac.sv
design/naive_dft_engine.sv
dv/tb_top.sv
